@@ sv/wrle_pkg.sv @@
package wrle_pkg;

    localparam int MAX_WORDS  = 4;
    localparam int MAX_RUN    = 64;
    localparam int COUNT_BITS = 24;

    localparam int WORD_BITS  = 32;
    localparam int IDX_BITS   = 24;
    localparam int WPE_BITS   = 3;
    localparam int ELEM_WORDS = 4;
    localparam int PART_WORDS = ELEM_WORDS - 1;
    localparam int WIDTH_LIM  = (MAX_WORDS < ELEM_WORDS) ? MAX_WORDS : ELEM_WORDS;
    localparam int RUN_BITS   = $clog2(MAX_RUN + 1);
    localparam int WANT_BITS  = (COUNT_BITS > IDX_BITS) ? COUNT_BITS : IDX_BITS;

    localparam logic [WORD_BITS-1:0] ESC_INC  = 32'h4FFF_FFFC;
    localparam logic [WORD_BITS-1:0] ESC_REP  = 32'h4FFF_FFFD;
    localparam logic [WORD_BITS-1:0] ESC_SKIP = 32'h4FFF_FFFE;
    localparam logic [WORD_BITS-1:0] ESC_END  = 32'h4FFF_FFFF;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic {
        CFG_WORDS_PER_ELEMENT = 1'b0,
        CFG_ELEMENT_COUNT     = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_HEADER,
        MODE_BOUNDARY,
        MODE_LITERAL,
        MODE_INC_COUNT,
        MODE_REP_COUNT,
        MODE_SKIP,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CALC,
        SEQ_RUN
    } seq_t;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_BITS-1:0]  idx_t;

endpackage

@@ sv/word_run_length_expander_top.sv @@
// Run-length expander for 32-bit word streams. The first word of a block is a header and is
// dropped; at element boundaries the escape words 0x4FFFFFFC/0x4FFFFFFD (each followed by a
// count) repeat the previous element with or without incrementing its last word, 0x4FFFFFFE
// skips one word and 0x4FFFFFFF emits an end marker and stops the block until reset. Literal
// words are taken one per cycle unless the output stalls; a completed element appears on
// the cycle after its last word. SEQ_CALC sizes a count word's run, then SEQ_RUN sends one
// element per cycle while the output is free, from a shared incrementer and a single output
// register; input waits until the run ends (at most 64; longer runs are cut and flagged).
// Configure words_per_element and element_count only while the block is idle.
module word_run_length_expander_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [wrle_pkg::IDX_BITS-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_stream_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_result_kind,
    output logic [31:0]                   m_word_zero,
    output logic [31:0]                   m_word_one,
    output logic [31:0]                   m_word_two,
    output logic [31:0]                   m_word_three,
    output logic [23:0]                   m_element_index,
    output logic                          m_last_of_run,
    output logic                          m_run_truncated
);
    import wrle_pkg::*;

    logic [WPE_BITS-1:0]   wpe_reg, wpe_next;
    idx_t                  ecount_reg, ecount_next;
    word_t                 prev_reg [ELEM_WORDS];
    word_t                 prev_next [ELEM_WORDS];
    word_t                 part_reg [PART_WORDS];
    word_t                 part_next [PART_WORDS];
    idx_t                  done_reg, done_next;
    logic [1:0]            wpos_reg, wpos_next;
    mode_t                 mode_reg, mode_next;
    seq_t                  seq_reg, seq_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  inc_reg, inc_next;
    logic [RUN_BITS-1:0]   left_reg, left_next;
    logic                  trunc_reg, trunc_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  kind_reg, kind_next;
    word_t                 out_reg [ELEM_WORDS];
    word_t                 out_next [ELEM_WORDS];
    idx_t                  oidx_reg, oidx_next;
    logic                  last_reg, last_next;
    logic                  otrunc_reg, otrunc_next;

    logic [WPE_BITS-1:0]   width;
    logic [WPE_BITS-1:0]   width_m1;
    logic [1:0]            last_sel;
    logic                  out_free;
    logic                  in_acc;
    idx_t                  remaining;
    logic [COUNT_BITS-1:0] mag;
    logic [WANT_BITS-1:0]  want;
    word_t                 el [ELEM_WORDS];

    always_comb begin
        if (wpe_reg == '0) begin
            width = WPE_BITS'(1);
        end else if (wpe_reg > WPE_BITS'(WIDTH_LIM)) begin
            width = WPE_BITS'(WIDTH_LIM);
        end else begin
            width = wpe_reg;
        end
    end

    assign width_m1  = width - WPE_BITS'(1);
    assign last_sel  = width_m1[1:0];
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (seq_reg == SEQ_IDLE) && out_free;
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign remaining = (done_reg < ecount_reg) ? (ecount_reg - done_reg) : '0;
    assign mag       = -count_reg;

    always_comb begin
        if (count_reg == '0) begin
            want = '0;
        end else if (count_reg[COUNT_BITS-1]) begin
            want = WANT_BITS'(mag);
        end else begin
            want = WANT_BITS'(remaining);
        end
        if (want > WANT_BITS'(remaining)) begin
            want = WANT_BITS'(remaining);
        end
    end

    always_comb begin
        wpe_next     = wpe_reg;
        ecount_next  = ecount_reg;
        prev_next    = prev_reg;
        part_next    = part_reg;
        done_next    = done_reg;
        wpos_next    = wpos_reg;
        mode_next    = mode_reg;
        seq_next     = seq_reg;
        count_next   = count_reg;
        inc_next     = inc_reg;
        left_next    = left_reg;
        trunc_next   = trunc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        out_next     = out_reg;
        oidx_next    = oidx_reg;
        last_next    = last_reg;
        otrunc_next  = otrunc_reg;
        el           = prev_reg;

        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_WORDS_PER_ELEMENT: wpe_next    = cfg_data[WPE_BITS-1:0];
                CFG_ELEMENT_COUNT:     ecount_next = cfg_data;
                default:               ecount_next = ecount_reg;
            endcase
        end

        case (seq_reg)
            SEQ_IDLE: begin
                if (in_acc) begin
                    case (mode_reg)
                        MODE_HEADER: begin
                            mode_next = MODE_BOUNDARY;
                            wpos_next = '0;
                        end
                        MODE_SKIP: begin
                            mode_next = MODE_BOUNDARY;
                        end
                        MODE_INC_COUNT, MODE_REP_COUNT: begin
                            mode_next  = MODE_BOUNDARY;
                            count_next = s_stream_word[COUNT_BITS-1:0];
                            inc_next   = (mode_reg == MODE_INC_COUNT);
                            seq_next   = SEQ_CALC;
                        end
                        MODE_BOUNDARY, MODE_LITERAL: begin
                            if (mode_reg == MODE_BOUNDARY && done_reg >= ecount_reg) begin
                                mode_next = MODE_DONE;
                            end else if (mode_reg == MODE_BOUNDARY &&
                                         s_stream_word == ESC_INC) begin
                                mode_next = MODE_INC_COUNT;
                            end else if (mode_reg == MODE_BOUNDARY &&
                                         s_stream_word == ESC_REP) begin
                                mode_next = MODE_REP_COUNT;
                            end else if (mode_reg == MODE_BOUNDARY &&
                                         s_stream_word == ESC_SKIP) begin
                                mode_next = MODE_SKIP;
                            end else if (mode_reg == MODE_BOUNDARY &&
                                         s_stream_word == ESC_END) begin
                                m_valid_next = 1'b1;
                                kind_next    = KIND_END;
                                for (int j = 0; j < ELEM_WORDS; j++) begin
                                    out_next[j] = '0;
                                end
                                oidx_next   = done_reg;
                                last_next   = 1'b1;
                                otrunc_next = 1'b0;
                                mode_next   = MODE_DONE;
                            end else begin
                                logic [1:0] wp;
                                wp = (mode_reg == MODE_BOUNDARY) ? 2'd0 : wpos_reg;
                                if ({1'b0, wp} + WPE_BITS'(1) >= width) begin
                                    for (int j = 0; j < ELEM_WORDS; j++) begin
                                        if (j < PART_WORDS && 2'(j) < wp) begin
                                            el[j] = part_reg[j];
                                        end else if (2'(j) == wp) begin
                                            el[j] = s_stream_word;
                                        end else begin
                                            el[j] = '0;
                                        end
                                        prev_next[j] = (WPE_BITS'(j) < width) ? el[j] : '0;
                                        out_next[j]  = prev_next[j];
                                    end
                                    m_valid_next = 1'b1;
                                    kind_next    = KIND_ELEMENT;
                                    oidx_next    = done_reg;
                                    last_next    = 1'b1;
                                    otrunc_next  = 1'b0;
                                    done_next    = done_reg + IDX_BITS'(1);
                                    wpos_next    = '0;
                                    mode_next    = MODE_BOUNDARY;
                                end else begin
                                    for (int j = 0; j < PART_WORDS; j++) begin
                                        if (2'(j) == wp) begin
                                            part_next[j] = s_stream_word;
                                        end
                                    end
                                    wpos_next = wp + 2'd1;
                                    mode_next = MODE_LITERAL;
                                end
                            end
                        end
                        default: begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            SEQ_CALC: begin
                if (want == '0) begin
                    seq_next = SEQ_IDLE;
                end else if (want > WANT_BITS'(MAX_RUN)) begin
                    left_next  = RUN_BITS'(MAX_RUN);
                    trunc_next = 1'b1;
                    seq_next   = SEQ_RUN;
                end else begin
                    left_next  = want[RUN_BITS-1:0];
                    trunc_next = 1'b0;
                    seq_next   = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (out_free) begin
                    if (inc_reg) begin
                        prev_next[last_sel] = prev_reg[last_sel] + WORD_BITS'(1);
                    end
                    for (int j = 0; j < ELEM_WORDS; j++) begin
                        out_next[j] = (WPE_BITS'(j) < width) ? prev_next[j] : '0;
                    end
                    m_valid_next = 1'b1;
                    kind_next    = KIND_ELEMENT;
                    oidx_next    = done_reg;
                    last_next    = (left_reg == RUN_BITS'(1));
                    otrunc_next  = trunc_reg;
                    done_next    = done_reg + IDX_BITS'(1);
                    left_next    = left_reg - RUN_BITS'(1);
                    if (left_reg == RUN_BITS'(1)) begin
                        seq_next = SEQ_IDLE;
                    end
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpe_reg     <= WPE_BITS'(1);
            ecount_reg  <= '0;
            done_reg    <= '0;
            wpos_reg    <= '0;
            mode_reg    <= MODE_HEADER;
            seq_reg     <= SEQ_IDLE;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < ELEM_WORDS; j++) begin
                prev_reg[j] <= '0;
            end
        end else begin
            wpe_reg     <= wpe_next;
            ecount_reg  <= ecount_next;
            done_reg    <= done_next;
            wpos_reg    <= wpos_next;
            mode_reg    <= mode_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
            prev_reg    <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        part_reg   <= part_next;
        count_reg  <= count_next;
        inc_reg    <= inc_next;
        left_reg   <= left_next;
        trunc_reg  <= trunc_next;
        kind_reg   <= kind_next;
        out_reg    <= out_next;
        oidx_reg   <= oidx_next;
        last_reg   <= last_next;
        otrunc_reg <= otrunc_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_word_zero     = out_reg[0];
    assign m_word_one      = out_reg[1];
    assign m_word_two      = out_reg[2];
    assign m_word_three    = out_reg[3];
    assign m_element_index = oidx_reg;
    assign m_last_of_run   = last_reg;
    assign m_run_truncated = otrunc_reg;

endmodule
